[hdl/ckf_pkg.sv]
`default_nettype none
// Shared constants, types and helper functions of the color key neighbor fill block.
package ckf_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned CH_W          = 8;
	localparam int unsigned FW_W          = 11;
	localparam int unsigned CFG_IDX_W     = 4;
	localparam int unsigned CFG_DATA_W    = FW_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RED_FLOOR     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_CEILING = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_FLOOR    = CFG_IDX_W'(3);

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = FW_W'(1024);
	localparam logic [CH_W-1:0] RED_FLOOR_RST     = CH_W'(250);
	localparam logic [CH_W-1:0] GREEN_CEILING_RST = CH_W'(5);
	localparam logic [CH_W-1:0] BLUE_FLOOR_RST    = CH_W'(250);

	localparam logic CMD_PIXEL = 1'b0;

	// 3x3 window, tap 0 is the newest item, tap 4 the center
	localparam int unsigned WIN_TAPS   = 9;
	localparam int unsigned CENTER_TAP = 4;

	localparam int unsigned SUM_W    = 11;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned RECIP_W  = 17;
	localparam int unsigned RECIP_SH = 16;
	localparam int unsigned PROD_W   = SUM_W + RECIP_W;

	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		logic  vld;
		chan_t r;
		chan_t g;
		chan_t b;
		chan_t a;
	} pix_t;

	typedef struct packed {
		chan_t red_floor;
		chan_t green_ceiling;
		chan_t blue_floor;
	} key_cfg_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
		chan_t a;
		logic  keyed;
	} res_t;

	typedef struct packed {
		logic v_s3;
		logic v_s4;
	} fill_st_t;

	function automatic logic key_match(pix_t p, key_cfg_t k);
		return (p.r > k.red_floor) && (p.g < k.green_ceiling) && (p.b > k.blue_floor);
	endfunction

	// ceil(2^16 / n); exact quotient for sums below 2^11 and n up to 8
	function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			CNT_W'(1): m = RECIP_W'(65536);
			CNT_W'(2): m = RECIP_W'(32768);
			CNT_W'(3): m = RECIP_W'(21846);
			CNT_W'(4): m = RECIP_W'(16384);
			CNT_W'(5): m = RECIP_W'(13108);
			CNT_W'(6): m = RECIP_W'(10923);
			CNT_W'(7): m = RECIP_W'(9363);
			CNT_W'(8): m = RECIP_W'(8192);
			default:   m = '0;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

[hdl/ckf_ifs.sv]
`default_nettype none
// Channel interfaces: pixel input, fill result output, register write port.

interface ckf_pix_if;
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic [ckf_pkg::CH_W-1:0] red_in;
	logic [ckf_pkg::CH_W-1:0] green_in;
	logic [ckf_pkg::CH_W-1:0] blue_in;
	logic [ckf_pkg::CH_W-1:0] alpha_in;

	modport source (output valid, command, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, command, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface ckf_res_if;
	logic                    valid;
	logic                    ready;
	logic [ckf_pkg::CH_W-1:0] red_out;
	logic [ckf_pkg::CH_W-1:0] green_out;
	logic [ckf_pkg::CH_W-1:0] blue_out;
	logic [ckf_pkg::CH_W-1:0] alpha_out;
	logic                    was_keyed;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, was_keyed,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, was_keyed,
		output ready);
endinterface

interface ckf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ckf_pkg::CFG_IDX_W-1:0]  index;
	logic [ckf_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/ckf_fill.sv]
`default_nettype none
// Key test, neighbor sums and reciprocal-multiply average over one 3x3 window.
module ckf_fill (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        win_vld,
	input  wire ckf_pkg::pix_t [ckf_pkg::WIN_TAPS-1:0]       win,
	input  wire ckf_pkg::key_cfg_t                           key_cfg,
	output logic                                             push,
	output ckf_pkg::res_t                                    push_data,
	output ckf_pkg::fill_st_t                                st
);

	logic [ckf_pkg::SUM_W-1:0]  sum_r, sum_g, sum_b;
	logic [ckf_pkg::CNT_W-1:0]  cnt;

	logic                       v_s3;
	logic [ckf_pkg::SUM_W-1:0]  sum_r_s3, sum_g_s3, sum_b_s3;
	logic [ckf_pkg::CNT_W-1:0]  cnt_s3;
	ckf_pkg::pix_t              ctr_s3;
	logic                       keyed_s3;

	logic                       v_s4;
	logic [ckf_pkg::PROD_W-1:0] prod_r_s4, prod_g_s4, prod_b_s4;
	logic                       has_n_s4;
	ckf_pkg::pix_t              ctr_s4;
	logic                       keyed_s4;

	logic [ckf_pkg::RECIP_W-1:0] recip_s3;

	// qualifying neighbors: present, not transparent, not keyed
	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		cnt   = '0;
		for (int i = 0; i < ckf_pkg::WIN_TAPS; i++) begin
			if (i != ckf_pkg::CENTER_TAP && win[i].vld && win[i].a != '0 &&
			    !ckf_pkg::key_match(win[i], key_cfg)) begin
				sum_r = sum_r + ckf_pkg::SUM_W'(win[i].r);
				sum_g = sum_g + ckf_pkg::SUM_W'(win[i].g);
				sum_b = sum_b + ckf_pkg::SUM_W'(win[i].b);
				cnt   = cnt + ckf_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= win_vld;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (win_vld) begin
			sum_r_s3 <= sum_r;
			sum_g_s3 <= sum_g;
			sum_b_s3 <= sum_b;
			cnt_s3   <= cnt;
			ctr_s3   <= win[ckf_pkg::CENTER_TAP];
			keyed_s3 <= ckf_pkg::key_match(win[ckf_pkg::CENTER_TAP], key_cfg);
		end
	end

	assign recip_s3 = ckf_pkg::recip(cnt_s3);

	always_ff @(posedge clk) begin
		if (v_s3) begin
			prod_r_s4 <= ckf_pkg::PROD_W'(sum_r_s3) * ckf_pkg::PROD_W'(recip_s3);
			prod_g_s4 <= ckf_pkg::PROD_W'(sum_g_s3) * ckf_pkg::PROD_W'(recip_s3);
			prod_b_s4 <= ckf_pkg::PROD_W'(sum_b_s3) * ckf_pkg::PROD_W'(recip_s3);
			has_n_s4  <= cnt_s3 != '0;
			ctr_s4    <= ctr_s3;
			keyed_s4  <= keyed_s3;
		end
	end

	always_comb begin
		push_data.r     = ctr_s4.r;
		push_data.g     = ctr_s4.g;
		push_data.b     = ctr_s4.b;
		push_data.a     = ctr_s4.a;
		push_data.keyed = keyed_s4;
		if (keyed_s4) begin
			push_data.a = '0;
			if (has_n_s4) begin
				push_data.r = prod_r_s4[ckf_pkg::RECIP_SH +: ckf_pkg::CH_W];
				push_data.g = prod_g_s4[ckf_pkg::RECIP_SH +: ckf_pkg::CH_W];
				push_data.b = prod_b_s4[ckf_pkg::RECIP_SH +: ckf_pkg::CH_W];
			end
		end
	end

	// an empty center slot produces no result
	assign push    = v_s4 && ctr_s4.vld;
	assign st.v_s3 = v_s3;
	assign st.v_s4 = v_s4;

endmodule
`default_nettype wire

[hdl/color_key_neighbour_fill_core.sv]
`default_nettype none
// Throughput: one pixel request per clock given FIFO credit; a frame_width write stalls input.
// A center pixel's result follows the request W+1 items later, via RAM read, rows, fill and FIFO.
// The window store is a single 2*MAX_WIDTH+3 entry RAM; two read ports feed rows W and 2W.
// Reset: registers to defaults, window empty via a fill counter (no RAM clearing pass).
// Results queue in an 8-entry FIFO, so input stays open while a result waits.
module color_key_neighbour_fill_core #(
	parameter int unsigned MAX_WIDTH = ckf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ckf_pix_if.sink   pix,
	ckf_res_if.source res,
	ckf_cfg_if.sink   cfg
);

	// Window geometry. Delay d is the item that arrived d requests before the
	// newest one; a step's taps sit at delays 0..2, W..W+2 and 2W..2W+2.
	localparam int unsigned DEPTH = 2 * MAX_WIDTH + 3;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned FCW   = $clog2(DEPTH + 1);
	localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned OCC_W = ckf_pkg::FIFO_AW + 2;

	// Window reload sequencer, only active after a frame_width write.
	typedef enum logic [3:0] {
		ST_RUN    = 4'b0001,
		ST_PRIME0 = 4'b0010,
		ST_PRIME1 = 4'b0100,
		ST_PRIME2 = 4'b1000
	} state_t;

	state_t                       state_q;

	logic [ckf_pkg::FW_W-1:0]     fw_q;
	ckf_pkg::key_cfg_t            key_cfg_q;
	logic                         cfg_wr;

	logic [WW-1:0]                w_eff;
	logic [AW-1:0]                w_d, w2_d, d_a, d_b, addr_a, addr_b;
	logic [AW-1:0]                wr_ptr_q;
	logic [FCW-1:0]               fill_q, fill_nx;
	logic                         acc, rd_en;
	ckf_pkg::pix_t                in_pix;

	ckf_pkg::pix_t                mem [DEPTH];
	ckf_pkg::pix_t                rd_a_s1, rd_b_s1, pix_s1, tap_a, tap_b;
	logic                         ok_a_s1, ok_b_s1;
	logic                         v_s1, v_s2;

	ckf_pkg::pix_t [2:0]          row0_q, row1_q, row2_q;

	logic                         push;
	ckf_pkg::res_t                push_data;
	ckf_pkg::fill_st_t            fill_st;

	ckf_pkg::res_t                fifo_q [ckf_pkg::FIFO_DEPTH];
	ckf_pkg::res_t                head;
	logic [ckf_pkg::FIFO_AW-1:0]  fwp_q, frp_q;
	logic [ckf_pkg::FIFO_AW:0]    fcnt_q;
	logic                         pop;
	logic [OCC_W-1:0]             occ;

	// Slot that held delay d, counted back from base around the ring.
	function automatic logic [AW-1:0] back(logic [AW-1:0] base, logic [AW-1:0] d);
		logic [AW:0] t;
		t = {1'b0, base} + (AW+1)'(DEPTH) - {1'b0, d};
		if (t >= (AW+1)'(DEPTH))
			t = t - (AW+1)'(DEPTH);
		return t[AW-1:0];
	endfunction

	// ---------------------------------------------------------------------
	// Register port: always ready, writes land the same edge.
	// ---------------------------------------------------------------------
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= ckf_pkg::FRAME_WIDTH_RST;
			key_cfg_q <= '{red_floor:     ckf_pkg::RED_FLOOR_RST,
			               green_ceiling: ckf_pkg::GREEN_CEILING_RST,
			               blue_floor:    ckf_pkg::BLUE_FLOOR_RST};
		end else if (cfg_wr) begin
			case (cfg.index)
				ckf_pkg::REG_FRAME_WIDTH:   fw_q <= cfg.data;
				ckf_pkg::REG_RED_FLOOR:     key_cfg_q.red_floor <= cfg.data[ckf_pkg::CH_W-1:0];
				ckf_pkg::REG_GREEN_CEILING: key_cfg_q.green_ceiling <= cfg.data[ckf_pkg::CH_W-1:0];
				ckf_pkg::REG_BLUE_FLOOR:    key_cfg_q.blue_floor <= cfg.data[ckf_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Width clamp: zero acts as 1, anything above MAX_WIDTH acts as MAX_WIDTH.
	always_comb begin
		if (fw_q == '0)
			w_eff = WW'(1);
		else if (32'(fw_q) > 32'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(fw_q);
	end

	assign w_d  = AW'(w_eff);
	assign w2_d = AW'({w_eff, 1'b0});

	// ---------------------------------------------------------------------
	// Reload sequencer. In steady state the taps W+1, W+2, 2W+1, 2W+2 are the
	// previous step's W and 2W reads shifted along; a new width breaks that,
	// so those four taps are fetched directly before the next request.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else if (cfg_wr && cfg.index == ckf_pkg::REG_FRAME_WIDTH) begin
			state_q <= ST_PRIME0;
		end else begin
			case (state_q)
				ST_PRIME0: state_q <= ST_PRIME1;
				ST_PRIME1: state_q <= ST_PRIME2;
				ST_PRIME2: state_q <= ST_RUN;
				default:   state_q <= ST_RUN;
			endcase
		end
	end

	// Read delays, relative to the slot the next request writes.
	always_comb begin
		case (state_q)
			ST_PRIME0: begin
				d_a = w_d + AW'(1);
				d_b = w2_d + AW'(1);
			end
			ST_PRIME1: begin
				d_a = w_d + AW'(2);
				d_b = w2_d + AW'(2);
			end
			default: begin
				d_a = w_d;
				d_b = w2_d;
			end
		endcase
	end

	assign addr_a = back(wr_ptr_q, d_a);
	assign addr_b = back(wr_ptr_q, d_b);

	// ---------------------------------------------------------------------
	// Input side. The FIFO credit counts every request still in the pipe,
	// so a taken request always finds room for its result.
	// ---------------------------------------------------------------------
	assign occ = OCC_W'(fcnt_q) + OCC_W'(v_s1) + OCC_W'(v_s2)
	           + OCC_W'(fill_st.v_s3) + OCC_W'(fill_st.v_s4);

	assign pix.ready = (state_q == ST_RUN) && (occ < OCC_W'(ckf_pkg::FIFO_DEPTH));
	assign acc       = pix.valid && pix.ready;
	assign rd_en     = acc || state_q == ST_PRIME0 || state_q == ST_PRIME1;

	// flush requests enter the window as empty slots
	assign in_pix = '{vld: pix.command == ckf_pkg::CMD_PIXEL,
	                  r:   pix.red_in,
	                  g:   pix.green_in,
	                  b:   pix.blue_in,
	                  a:   pix.alpha_in};

	// Fill count stands in for per-entry valid bits after reset: a delay at or
	// beyond the number of writes so far reads as empty.
	assign fill_nx = (fill_q == FCW'(DEPTH)) ? fill_q : fill_q + FCW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			if (acc) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
				fill_q   <= fill_nx;
			end
		end
	end

	// Window RAM: one write, two registered reads per cycle. Reads never hit
	// the slot being written since every read delay is at least 1.
	always_ff @(posedge clk) begin
		if (acc)
			mem[wr_ptr_q] <= in_pix;
		if (rd_en) begin
			rd_a_s1 <= mem[addr_a];
			rd_b_s1 <= mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ok_a_s1 <= FCW'(d_a) < fill_nx;
			ok_b_s1 <= FCW'(d_b) < fill_nx;
		end
		if (acc)
			pix_s1 <= in_pix;
	end

	always_comb begin
		tap_a     = rd_a_s1;
		tap_a.vld = rd_a_s1.vld && ok_a_s1;
		tap_b     = rd_b_s1;
		tap_b.vld = rd_b_s1.vld && ok_b_s1;
	end

	// ---------------------------------------------------------------------
	// 3x3 window rows; index 0 is the newest of each row. Primed taps go into
	// slots 0 and 1 so the next request's shift moves them to W+1 and W+2.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= '0;
			row1_q <= '0;
			row2_q <= '0;
		end else if (v_s1) begin
			row0_q[0] <= pix_s1;
			row0_q[1] <= row0_q[0];
			row0_q[2] <= row0_q[1];
			row1_q[0] <= tap_a;
			row1_q[1] <= row1_q[0];
			row1_q[2] <= row1_q[1];
			row2_q[0] <= tap_b;
			row2_q[1] <= row2_q[0];
			row2_q[2] <= row2_q[1];
		end else if (state_q == ST_PRIME1) begin
			row1_q[0] <= tap_a;
			row2_q[0] <= tap_b;
		end else if (state_q == ST_PRIME2) begin
			row1_q[1] <= tap_a;
			row2_q[1] <= tap_b;
		end
	end

	// center is row1[1], i.e. delay W+1
	ckf_fill u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_vld   (v_s2),
		.win       ({row2_q, row1_q, row0_q}),
		.key_cfg   (key_cfg_q),
		.push      (push),
		.push_data (push_data),
		.st        (fill_st)
	);

	// ---------------------------------------------------------------------
	// Result FIFO.
	// ---------------------------------------------------------------------
	assign pop = res.valid && res.ready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[fwp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwp_q  <= '0;
			frp_q  <= '0;
			fcnt_q <= '0;
		end else begin
			if (push)
				fwp_q <= fwp_q + ckf_pkg::FIFO_AW'(1);
			if (pop)
				frp_q <= frp_q + ckf_pkg::FIFO_AW'(1);
			fcnt_q <= fcnt_q + (ckf_pkg::FIFO_AW+1)'(push) - (ckf_pkg::FIFO_AW+1)'(pop);
		end
	end

	assign head          = fifo_q[frp_q];
	assign res.valid     = fcnt_q != '0;
	assign res.red_out   = head.r;
	assign res.green_out = head.g;
	assign res.blue_out  = head.b;
	assign res.alpha_out = head.a;
	assign res.was_keyed = head.keyed;

endmodule
`default_nettype wire

[bench/ckf_fill_check.sv]
`timescale 1ns / 100ps
// Fill predictor and result comparison for the color key neighbor fill block.
module ckf_fill_check #(
	parameter int unsigned MAX_WIDTH = ckf_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ckf_pix_if          pix,
	ckf_res_if          res,
	ckf_cfg_if          cfg,
	output int unsigned fail_count,
	output int unsigned fills_due
);
	import ckf_pkg::*;

	localparam int unsigned DEPTH = 2 * MAX_WIDTH + 3;

	pix_t            history [DEPTH];
	int unsigned     next_slot;
	logic [FW_W-1:0] frame_width;
	key_cfg_t        key;
	res_t            expected_fills[$];

	function automatic bit is_keyed(pix_t p);
		return p.r > key.red_floor && p.g < key.green_ceiling && p.b > key.blue_floor;
	endfunction

	// slot of the request that came `delay` requests before the newest one
	function automatic int unsigned ago(int unsigned delay);
		return (next_slot + DEPTH - 1 - delay) % DEPTH;
	endfunction

	// store one request, return 1 and the filled center when the center tap holds a pixel
	function automatic bit push_pixel(pix_t item, output res_t fill);
		int unsigned w, cnt, sum_r, sum_g, sum_b;
		int          dy, dx, delay;
		pix_t        mid, nb;
		w = frame_width;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		history[next_slot] = item;
		next_slot = (next_slot + 1) % DEPTH;
		fill = '0;
		mid = history[ago(w + 1)];
		if (!mid.vld)
			return 1'b0;
		fill.r     = mid.r;
		fill.g     = mid.g;
		fill.b     = mid.b;
		fill.a     = mid.a;
		fill.keyed = is_keyed(mid);
		if (fill.keyed) begin
			cnt   = 0;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			for (dy = -1; dy <= 1; dy++) begin
				for (dx = -1; dx <= 1; dx++) begin
					delay = int'(w) + 1 - (dy * int'(w) + dx);
					nb = history[ago(delay)];
					if (nb.vld && nb.a != '0 && !is_keyed(nb)) begin
						sum_r += nb.r;
						sum_g += nb.g;
						sum_b += nb.b;
						cnt++;
					end
				end
			end
			if (cnt > 0) begin
				fill.r = chan_t'(sum_r / cnt);
				fill.g = chan_t'(sum_g / cnt);
				fill.b = chan_t'(sum_b / cnt);
			end
			fill.a = '0;
		end
		return 1'b1;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t        got, want;
		pix_t        item;
		int unsigned i;
		if (!arst_n) begin
			for (i = 0; i < DEPTH; i++)
				history[i] = '0;
			next_slot   = 0;
			frame_width = FRAME_WIDTH_RST;
			key         = '{RED_FLOOR_RST, GREEN_CEILING_RST, BLUE_FLOOR_RST};
			expected_fills.delete();
			fills_due   = 0;
			fail_count  = 0;
		end else begin
			// results first: a result can never stem from a request taken at the same edge
			if (res.valid && res.ready) begin
				got = '{res.red_out, res.green_out, res.blue_out, res.alpha_out, res.was_keyed};
				if (expected_fills.size() == 0) begin
					$error("result with no pending pixel: r %0d g %0d b %0d a %0d keyed %0d",
						got.r, got.g, got.b, got.a, got.keyed);
					fail_count++;
				end else begin
					want = expected_fills.pop_front();
					compare_field("red_out", want.r, got.r);
					compare_field("green_out", want.g, got.g);
					compare_field("blue_out", want.b, got.b);
					compare_field("alpha_out", want.a, got.a);
					compare_field("was_keyed", want.keyed, got.keyed);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_FRAME_WIDTH:   frame_width       = cfg.data[FW_W-1:0];
					REG_RED_FLOOR:     key.red_floor     = cfg.data[CH_W-1:0];
					REG_GREEN_CEILING: key.green_ceiling = cfg.data[CH_W-1:0];
					REG_BLUE_FLOOR:    key.blue_floor    = cfg.data[CH_W-1:0];
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				item = '{pix.command == CMD_PIXEL, pix.red_in, pix.green_in, pix.blue_in,
					pix.alpha_in};
				if (push_pixel(item, want))
					expected_fills.push_back(want);
			end
			fills_due = expected_fills.size();
		end
	end

endmodule

[bench/tb_color_key_neighbour_fill_core.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, pixel and register stimulus, and verdict for the fill core.
module tb_color_key_neighbour_fill_core;
	import ckf_pkg::*;

	localparam int unsigned RANDOM_PIXELS = 360;
	// covers the result pipeline plus window reload after a width write, with margin
	localparam int unsigned SETTLE_CYCLES = 16;
	// slowest run is under a thousand requests plus settling, well inside this limit
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned IDLE_PCT      = 15;

	localparam logic                 CMD_FLUSH    = ~CMD_PIXEL;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(15);
	localparam logic [FW_W-1:0]      WIDTH_OVER   = FW_W'(2047);
	localparam int unsigned          PAD_W        = CFG_DATA_W - CH_W;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        pix_fire = 1'b0;
	logic        cfg_fire = 1'b0;
	bit          calm = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned fail_count;
	int unsigned fills_due;

	// stimulus side copy of the registers, used to aim pixels at the key
	logic [FW_W-1:0] width_now;
	key_cfg_t        key_now;

	ckf_pix_if pix_ch();
	ckf_res_if res_ch();
	ckf_cfg_if cfg_ch();

	color_key_neighbour_fill_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	ckf_fill_check fill_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.fills_due  (fills_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Handshakes are registered at the rising edge and read by the tasks at the
	// falling edge, so stimulus never races the block's own updates.
	always @(posedge clk) begin
		pix_fire    <= pix_ch.valid && pix_ch.ready;
		cfg_fire    <= cfg_ch.valid && cfg_ch.ready;
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_color_key_neighbour_fill_core NOT OK");
			$finish;
		end
	end

	// Result side back-pressure: about 15% stall, none during the calm stretch.
	always @(negedge clk)
		res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// effective width: 0 acts as 1, anything above the line buffer acts as its size
	function automatic int unsigned width_used();
		if (width_now == '0)
			return 1;
		if (width_now > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return width_now;
	endfunction

	function automatic pix_t px(chan_t r, chan_t g, chan_t b, chan_t a);
		return '{1'b1, r, g, b, a};
	endfunction

	// Mix: keyed pixels, unkeyed opaque, unkeyed transparent, saturated channels, noise.
	function automatic pix_t make_pixel();
		pix_t        p;
		int unsigned pick;
		bit          can_key;
		pick    = $urandom_range(99);
		can_key = key_now.red_floor != 8'hFF && key_now.green_ceiling != 8'h00 &&
			key_now.blue_floor != 8'hFF;
		p = pix_t'({1'b1, $urandom});
		if (pick < 35 && can_key) begin
			p.r = chan_t'($urandom_range(255, key_now.red_floor + 1));
			p.g = chan_t'($urandom_range(key_now.green_ceiling - 1, 0));
			p.b = chan_t'($urandom_range(255, key_now.blue_floor + 1));
		end else if (pick < 80) begin
			// push red under its floor if the noise happened to key
			if (p.r > key_now.red_floor && p.g < key_now.green_ceiling &&
				p.b > key_now.blue_floor)
				p.r = chan_t'($urandom_range(key_now.red_floor, 0));
			if (pick >= 70)
				p.a = '0;
			else if (p.a == '0)
				p.a = 8'hFF;
		end else if (pick < 90) begin
			p.r = {CH_W{$urandom_range(1) == 1}};
			p.g = {CH_W{$urandom_range(1) == 1}};
			p.b = {CH_W{$urandom_range(1) == 1}};
			p.a = {CH_W{$urandom_range(1) == 1}};
		end
		return p;
	endfunction

	// threshold choice: the two extremes, the reset value, or anything
	function automatic chan_t pick_level(chan_t dflt);
		case ($urandom_range(5))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return dflt;
			default: return chan_t'($urandom);
		endcase
	endfunction

	// One pixel or flush request, with random idle cycles ahead of it.
	// Returns at the falling edge after acceptance with valid still high.
	task automatic send(logic cmd, pix_t p);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid    <= 1'b1;
		pix_ch.command  <= cmd;
		pix_ch.red_in   <= p.r;
		pix_ch.green_in <= p.g;
		pix_ch.blue_in  <= p.b;
		pix_ch.alpha_in <= p.a;
		do @(negedge clk); while (!pix_fire);
	endtask

	// flush payload is don't-care, so randomize it to toggle every input bit
	task automatic send_flush(int unsigned count);
		repeat (count)
			send(CMD_FLUSH, pix_t'({$urandom, $urandom}));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(negedge clk); while (!cfg_fire);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:   width_now             = data[FW_W-1:0];
			REG_RED_FLOOR:     key_now.red_floor     = data[CH_W-1:0];
			REG_GREEN_CEILING: key_now.green_ceiling = data[CH_W-1:0];
			REG_BLUE_FLOOR:    key_now.blue_floor    = data[CH_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Hold off until every predicted result is back, then let the pipe go quiet;
	// a request that produced no result may still be in flight at that point.
	task automatic settle();
		pix_ch.valid <= 1'b0;
		while (fills_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// Width plus random thresholds; the unused upper data bits are randomized too.
	task automatic load_config(logic [FW_W-1:0] w);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_RED_FLOOR, {PAD_W'($urandom), pick_level(RED_FLOOR_RST)});
		write_reg(REG_GREEN_CEILING, {PAD_W'($urandom), pick_level(GREEN_CEILING_RST)});
		write_reg(REG_BLUE_FLOOR, {PAD_W'($urandom), pick_level(BLUE_FLOOR_RST)});
	endtask

	task automatic send_pixels(int unsigned count);
		repeat (count)
			send(CMD_PIXEL, make_pixel());
	endtask

	initial begin : stimulus
		int unsigned pixels_done, len, w, roll;
		arst_n           = 1'b0;
		pix_ch.valid     = 1'b0;
		pix_ch.command   = CMD_PIXEL;
		pix_ch.red_in    = '0;
		pix_ch.green_in  = '0;
		pix_ch.blue_in   = '0;
		pix_ch.alpha_in  = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_FRAME_WIDTH;
		cfg_ch.data      = '0;
		res_ch.ready     = 1'b0;
		width_now        = FRAME_WIDTH_RST;
		key_now          = '{RED_FLOOR_RST, GREEN_CEILING_RST, BLUE_FLOOR_RST};
		repeat (11)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part ---
		// a write to an unmapped index must change nothing
		write_reg(REG_UNMAPPED, '1);
		write_reg(REG_FRAME_WIDTH, FW_W'(3));
		write_reg(REG_RED_FLOOR, {3'b101, RED_FLOOR_RST});
		write_reg(REG_GREEN_CEILING, {PAD_W'(0), GREEN_CEILING_RST});
		write_reg(REG_BLUE_FLOOR, {PAD_W'(0), BLUE_FLOOR_RST});

		// 3x3 frame, keyed center; neighbors cover keyed, transparent, opaque and the
		// green boundary (green equal to the ceiling does not key)
		send(CMD_PIXEL, px(8'd255, 8'd0, 8'd255, 8'd255));
		send(CMD_PIXEL, px(8'd0, 8'd0, 8'd0, 8'd255));
		send(CMD_PIXEL, px(8'd255, 8'd255, 8'd255, 8'd0));
		send(CMD_PIXEL, px(8'd200, 8'd100, 8'd50, 8'd255));
		send(CMD_PIXEL, px(8'd251, 8'd4, 8'd251, 8'd128));
		send(CMD_PIXEL, px(8'd10, 8'd20, 8'd30, 8'd1));
		send(CMD_PIXEL, px(8'd255, 8'd0, 8'd255, 8'd0));
		send(CMD_PIXEL, px(8'd255, 8'd255, 8'd255, 8'd255));
		send(CMD_PIXEL, px(8'd251, 8'd5, 8'd251, 8'd255));
		send_flush(4);

		// two keyed pixels with nothing usable around: RGB passes through
		send(CMD_PIXEL, px(8'd251, 8'd0, 8'd252, 8'd77));
		send(CMD_PIXEL, px(8'd254, 8'd3, 8'd255, 8'd255));
		send_flush(4);

		// width 0 behaves as width 1
		settle();
		load_config(FW_W'(0));
		send_pixels(30);
		send_flush(width_used() + 1);

		// width beyond the line buffer behaves as the full buffer: no pixel reaches
		// the center, and all of them stay in the window unflushed
		settle();
		load_config(WIDTH_OVER);
		send_pixels(40);

		// width change with pixels still in the window: the leftover wide-frame
		// pixels surface as centers at width 8, the three new pixels produce
		// nothing there and the last two of them come out once width drops to 1
		settle();
		load_config(FW_W'(8));
		send_pixels(3);
		settle();
		write_reg(REG_FRAME_WIDTH, FW_W'(1));
		send_pixels(30);
		send_flush(width_used() + 1);

		// --- random part ---
		// Each frame gets a fresh setting; most frames are drained by a flush, about
		// one in ten is not, so the next frame sees stale neighbors.
		pixels_done = 0;
		while (pixels_done < RANDOM_PIXELS) begin
			settle();
			calm = pixels_done >= 140 && pixels_done < 240;
			roll = $urandom_range(99);
			if (roll < 5)
				w = 0;
			else if (roll < 12)
				w = 1;
			else if (roll < 88)
				w = $urandom_range(16, 2);
			else
				w = $urandom_range(64, 17);
			load_config(FW_W'(w));
			len = $urandom_range(3 * width_used() + 3, width_used() + 1);
			if (len > 96)
				len = 96;
			send_pixels(len);
			pixels_done += len;
			if ($urandom_range(9) != 0)
				send_flush(width_used() + 1);
		end
		calm = 1'b0;
		send_flush(width_used() + 1);

		settle();
		if (fail_count == 0 && fills_due == 0)
			$display("tb_color_key_neighbour_fill_core OK");
		else
			$display("tb_color_key_neighbour_fill_core NOT OK");
		$finish;
	end

endmodule
